FILE: rtl/pfe_pkg.sv
package pfe_pkg;

  localparam int unsigned STACK_DEPTH   = 32;
  localparam int unsigned TABLE_COUNT   = 8;
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned STACK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned TBL_AW   = $clog2(TABLE_COUNT * TABLE_ENTRIES);
  localparam int unsigned ENT_AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 32;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  localparam logic signed [31:0] FX_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] FX_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] FX_ZERO = 32'sh0000_0000;
  localparam logic signed [31:0] FX_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] FX_MIN  = 32'sh8000_0000;

  localparam logic [1:0] CMD_TOKEN = 2'd0;
  localparam logic [1:0] CMD_ENTRY = 2'd1;
  localparam logic [1:0] CMD_DESC  = 2'd2;

  localparam logic [4:0] OP_BAD  = 5'd0;
  localparam logic [4:0] OP_NUM  = 5'd1;
  localparam logic [4:0] OP_TIME = 5'd2;
  localparam logic [4:0] OP_PAR0 = 5'd3;
  localparam logic [4:0] OP_PAR1 = 5'd4;
  localparam logic [4:0] OP_PAR2 = 5'd5;
  localparam logic [4:0] OP_PAR3 = 5'd6;
  localparam logic [4:0] OP_PAR4 = 5'd7;
  localparam logic [4:0] OP_ONE  = 5'd8;
  localparam logic [4:0] OP_HALF = 5'd9;
  localparam logic [4:0] OP_ZERO = 5'd10;
  localparam logic [4:0] OP_NEG  = 5'd11;
  localparam logic [4:0] OP_TBL  = 5'd12;
  localparam logic [4:0] OP_AND  = 5'd13;
  localparam logic [4:0] OP_OR   = 5'd14;
  localparam logic [4:0] OP_GE   = 5'd15;
  localparam logic [4:0] OP_LE   = 5'd16;
  localparam logic [4:0] OP_EQ   = 5'd17;
  localparam logic [4:0] OP_NE   = 5'd18;
  localparam logic [4:0] OP_ADD  = 5'd19;
  localparam logic [4:0] OP_SUB  = 5'd20;
  localparam logic [4:0] OP_DIV  = 5'd21;
  localparam logic [4:0] OP_MOD  = 5'd22;
  localparam logic [4:0] OP_MUL  = 5'd23;
  localparam logic [4:0] OP_LT   = 5'd24;
  localparam logic [4:0] OP_GT   = 5'd25;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam logic [2:0] REG_FRAME_TIME   = 3'd0;
  localparam logic [2:0] REG_PARAM_SOURCE = 3'd1;
  localparam logic [2:0] REG_LIGHT_RED    = 3'd2;
  localparam logic [2:0] REG_LIGHT_GREEN  = 3'd3;
  localparam logic [2:0] REG_LIGHT_BLUE   = 3'd4;
  localparam logic [2:0] REG_ENTITY_RGBA  = 3'd5;
  localparam logic [2:0] REG_SHADER_TIME  = 3'd6;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_ENTRY_WR,
    CLS_DESC_WR,
    CLS_BAD,
    CLS_PUSH,
    CLS_UNARY,
    CLS_BINARY
  } cls_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [4:0]         opcode;
    logic signed [31:0] operand;
    logic [2:0]         table_number;
    logic [7:0]         entry_index;
    logic [8:0]         table_length;
    logic               table_clamp;
    logic               table_snap;
    logic signed [31:0] default_value;
    logic               last_token;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    in_t  item;
    cls_e cls;
  } tok_t;

  typedef struct packed {
    logic signed [31:0] frame_time;
    logic [1:0]         param_source;
    logic signed [31:0] light_red;
    logic signed [31:0] light_green;
    logic signed [31:0] light_blue;
    logic [31:0]        entity_rgba;
    logic signed [31:0] shader_time;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      r = FX_MAX;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = FX_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

  // byte * 65536 / 255 rounded: 257 * b plus one for the upper half of the range
  function automatic logic signed [31:0] byte_fx(input logic [7:0] b);
    logic [16:0] v;
    v = {1'b0, b, 8'd0} + {9'd0, b} + {16'd0, b[7]};
    return $signed({15'd0, v});
  endfunction

endpackage

FILE: rtl/pfe_ram.sv
module pfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pfe_div.sv
module pfe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pfe_pkg::DIV_NW-1:0] dividend_i,
  input  logic [pfe_pkg::DIV_DW-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [pfe_pkg::DIV_NW-1:0] quot_o,
  output logic [pfe_pkg::DIV_DW-1:0] rem_o
);

  logic [pfe_pkg::DIV_NW-1:0] quot_q, quot_d;
  logic [pfe_pkg::DIV_DW-1:0] rem_q, rem_d;
  logic [pfe_pkg::DIV_DW-1:0] dsr_q, dsr_d;
  logic [pfe_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [pfe_pkg::DIV_DW:0]   trial;
  logic [pfe_pkg::DIV_DW:0]   diff;
  logic                       fits;

  // One quotient bit per cycle, restoring.
  always_comb begin
    trial  = {rem_q, quot_q[pfe_pkg::DIV_NW-1]};
    diff   = trial - {1'b0, dsr_q};
    fits   = (trial >= {1'b0, dsr_q});
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = pfe_pkg::DIV_CW'(pfe_pkg::DIV_NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[pfe_pkg::DIV_NW-2:0], fits};
      rem_d  = fits ? diff[pfe_pkg::DIV_DW-1:0] : trial[pfe_pkg::DIV_DW-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == pfe_pkg::DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/pfe_front.sv
module pfe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pfe_pkg::in_t    in_data_i,
  output logic            tok_valid_o,
  input  logic            tok_pop_i,
  output pfe_pkg::tok_t   tok_o
);

  pfe_pkg::tok_t               ent_q [pfe_pkg::QUEUE_DEPTH];
  logic [pfe_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [pfe_pkg::QCNT_W-1:0]   cnt_q;
  logic                         push, pop;
  pfe_pkg::cls_e                cls;

  always_comb begin
    case (in_data_i.command)
      pfe_pkg::CMD_ENTRY: cls = pfe_pkg::CLS_ENTRY_WR;
      pfe_pkg::CMD_DESC:  cls = pfe_pkg::CLS_DESC_WR;
      pfe_pkg::CMD_TOKEN: begin
        if (in_data_i.opcode inside {[pfe_pkg::OP_NUM:pfe_pkg::OP_ZERO]}) begin
          cls = pfe_pkg::CLS_PUSH;
        end else if (in_data_i.opcode inside {pfe_pkg::OP_NEG, pfe_pkg::OP_TBL}) begin
          cls = pfe_pkg::CLS_UNARY;
        end else if (in_data_i.opcode inside {[pfe_pkg::OP_AND:pfe_pkg::OP_GT]}) begin
          cls = pfe_pkg::CLS_BINARY;
        end else begin
          cls = pfe_pkg::CLS_BAD;
        end
      end
      default: cls = pfe_pkg::CLS_IGNORE;
    endcase
  end

  assign in_stall_o  = (cnt_q == pfe_pkg::QCNT_W'(pfe_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign tok_valid_o = (cnt_q != '0);
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= '{item: in_data_i, cls: cls};
    end
  end

endmodule

FILE: rtl/pfe_back.sv
module pfe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfe_pkg::cfg_t cfg_i,
  input  logic          tok_valid_i,
  output logic          tok_pop_o,
  input  pfe_pkg::tok_t tok_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfe_pkg::out_t out_data_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_OP    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_LK1   = 4'd8;
  localparam logic [3:0] S_LKDIV = 4'd9;
  localparam logic [3:0] S_LK2   = 4'd10;
  localparam logic [3:0] S_LK3   = 4'd11;
  localparam logic [3:0] S_LK4   = 4'd12;
  localparam logic [3:0] S_LK5   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;
  localparam logic [3:0] S_LAST  = 4'd15;

  logic [3:0]                  state_q, state_d;
  pfe_pkg::tok_t               cur_q, cur_d;
  logic [pfe_pkg::CNT_W-1:0]   count_q, count_d;
  logic [1:0]                  err_q, err_d;
  logic signed [31:0]          a_q, a_d, b_q, b_d;
  logic signed [63:0]          prod_q, prod_d;
  logic [pfe_pkg::ENT_AW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic                        ipneg_q, ipneg_d;
  logic [15:0]                 frac_q, frac_d;
  logic [8:0]                  len_q [pfe_pkg::TABLE_COUNT];
  logic                        clamp_q [pfe_pkg::TABLE_COUNT];
  logic                        snap_q [pfe_pkg::TABLE_COUNT];
  logic                        out_valid_q, out_valid_d;
  pfe_pkg::out_t               out_q, out_d;

  logic                        s_we, s_re;
  logic [pfe_pkg::STACK_AW-1:0] s_waddr, s_raddr;
  logic signed [31:0]          s_wdata;
  logic [31:0]                 s_rdata;
  logic                        t_we, t_re;
  logic [pfe_pkg::TBL_AW-1:0]  t_waddr, t_raddr;
  logic [31:0]                 t_rdata;
  logic                        div_start, div_busy, div_done;
  logic [pfe_pkg::DIV_NW-1:0]  div_dvd, div_quot;
  logic [pfe_pkg::DIV_DW-1:0]  div_dsr, div_rem;
  logic                        desc_we;

  logic [pfe_pkg::STACK_AW-1:0] top_a, sec_a;
  logic [8:0]                  len;
  logic [8:0]                  len_m1;
  logic signed [25:0]          ip;
  logic signed [26:0]          ip1;
  logic [25:0]                 ip_mag;
  logic [31:0]                 a_mag, b_mag;
  logic signed [32:0]          sum33;
  logic signed [32:0]          dif33;
  logic signed [48:0]          q_signed;
  logic [8:0]                  wrap_r, wrap_lo;
  logic signed [31:0]          push_val;
  logic signed [31:0]          mod_val;
  logic signed [63:0]          rnd;
  logic [8:0]                  in_len;

  assign top_a  = count_q[pfe_pkg::STACK_AW-1:0] - pfe_pkg::STACK_AW'(1);
  assign sec_a  = count_q[pfe_pkg::STACK_AW-1:0] - pfe_pkg::STACK_AW'(2);
  assign len    = len_q[cur_q.item.table_number];
  assign len_m1 = len - 9'd1;
  assign ip     = prod_q[41:16];
  assign ip1    = {ip[25], ip} + 27'sd1;
  assign ip_mag = ip[25] ? 26'(-ip) : 26'(ip);
  assign a_mag  = a_q[31] ? 32'(-a_q) : 32'(a_q);
  assign b_mag  = b_q[31] ? 32'(-b_q) : 32'(b_q);
  assign sum33  = {a_q[31], a_q} + {b_q[31], b_q};
  assign dif33  = {a_q[31], a_q} - {b_q[31], b_q};
  assign wrap_r = div_rem[8:0];
  assign wrap_lo = (ipneg_q && wrap_r != 9'd0) ? len - wrap_r : wrap_r;
  assign in_len = (tok_i.item.table_length > 9'(pfe_pkg::TABLE_ENTRIES)) ?
                  9'(pfe_pkg::TABLE_ENTRIES) : tok_i.item.table_length;

  always_comb begin
    logic [1:0] src;
    src = cfg_i.param_source;
    case (cur_q.item.opcode)
      pfe_pkg::OP_NUM:  push_val = cur_q.item.operand;
      pfe_pkg::OP_TIME: push_val = cfg_i.frame_time;
      pfe_pkg::OP_PAR0: push_val = src[1] ? cfg_i.light_red :
                                   (src != 2'd0) ? pfe_pkg::byte_fx(cfg_i.entity_rgba[31:24]) :
                                   pfe_pkg::FX_ONE;
      pfe_pkg::OP_PAR1: push_val = src[1] ? cfg_i.light_green :
                                   (src != 2'd0) ? pfe_pkg::byte_fx(cfg_i.entity_rgba[23:16]) :
                                   pfe_pkg::FX_ONE;
      pfe_pkg::OP_PAR2: push_val = src[1] ? cfg_i.light_blue :
                                   (src != 2'd0) ? pfe_pkg::byte_fx(cfg_i.entity_rgba[15:8]) :
                                   pfe_pkg::FX_ONE;
      pfe_pkg::OP_PAR3: push_val = src[1] ? pfe_pkg::FX_ONE :
                                   (src != 2'd0) ? pfe_pkg::byte_fx(cfg_i.entity_rgba[7:0]) :
                                   pfe_pkg::FX_ONE;
      pfe_pkg::OP_PAR4: push_val = (src != 2'd0) ? pfe_pkg::neg_sat(cfg_i.shader_time) :
                                   pfe_pkg::FX_ZERO;
      pfe_pkg::OP_ONE:  push_val = pfe_pkg::FX_ONE;
      pfe_pkg::OP_HALF: push_val = pfe_pkg::FX_HALF;
      default:          push_val = pfe_pkg::FX_ZERO;
    endcase
  end

  // Remainder of the integer parts, carrying the dividend's sign, back in Q16.16.
  always_comb begin
    logic signed [31:0] r;
    r = {div_rem[15:0], 16'd0};
    mod_val = a_q[31] ? -r : r;
  end

  always_comb begin
    q_signed = (a_q[31] ^ b_q[31]) ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    count_d     = count_q;
    err_d       = err_q;
    a_d         = a_q;
    b_d         = b_q;
    prod_d      = prod_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ipneg_d     = ipneg_q;
    frac_d      = frac_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tok_pop_o   = 1'b0;
    s_we        = 1'b0;
    s_waddr     = top_a;
    s_wdata     = pfe_pkg::FX_ZERO;
    s_re        = 1'b0;
    s_raddr     = top_a;
    t_we        = 1'b0;
    t_waddr     = {tok_i.item.table_number, tok_i.item.entry_index};
    t_re        = 1'b0;
    t_raddr     = {cur_q.item.table_number, lo_q};
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dsr     = '0;
    desc_we     = 1'b0;
    rnd         = '0;

    case (state_q)
      S_IDLE: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          case (tok_i.cls)
            pfe_pkg::CLS_ENTRY_WR: begin
              t_we = 1'b1;
            end
            pfe_pkg::CLS_DESC_WR: begin
              desc_we = 1'b1;
            end
            pfe_pkg::CLS_IGNORE: begin
            end
            default: begin
              cur_d   = tok_i;
              state_d = S_EXEC;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        if (err_q == pfe_pkg::ST_OK) begin
          case (cur_q.cls)
            pfe_pkg::CLS_PUSH: begin
              if (count_q >= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH)) begin
                err_d = pfe_pkg::ST_OVER;
              end else begin
                s_we    = 1'b1;
                s_waddr = count_q[pfe_pkg::STACK_AW-1:0];
                s_wdata = push_val;
                count_d = count_q + 1'b1;
              end
            end
            pfe_pkg::CLS_UNARY: begin
              if (count_q == '0) begin
                err_d = pfe_pkg::ST_UNDER;
              end else begin
                s_re    = 1'b1;
                state_d = S_RD1;
              end
            end
            pfe_pkg::CLS_BINARY: begin
              if (count_q < pfe_pkg::CNT_W'(2)) begin
                err_d = pfe_pkg::ST_UNDER;
              end else begin
                s_re    = 1'b1;
                state_d = S_RDB;
              end
            end
            default: err_d = pfe_pkg::ST_BAD;
          endcase
        end
      end
      S_RD1: begin
        if (cur_q.item.opcode == pfe_pkg::OP_NEG) begin
          s_we    = 1'b1;
          s_wdata = pfe_pkg::neg_sat(s_rdata);
          state_d = S_FIN;
        end else if (len == 9'd0) begin
          s_we    = 1'b1;
          s_wdata = pfe_pkg::FX_ZERO;
          state_d = S_FIN;
        end else begin
          prod_d  = 64'($signed(s_rdata) * $signed({1'b0, len}));
          state_d = S_LK1;
        end
      end
      S_RDB: begin
        b_d     = s_rdata;
        s_re    = 1'b1;
        s_raddr = sec_a;
        state_d = S_RDA;
      end
      S_RDA: begin
        a_d     = s_rdata;
        state_d = S_OP;
      end
      S_OP: begin
        s_waddr = sec_a;
        state_d = S_FIN;
        case (cur_q.item.opcode)
          pfe_pkg::OP_MUL: begin
            prod_d  = a_q * b_q;
            state_d = S_MUL;
          end
          pfe_pkg::OP_DIV: begin
            if (b_q == pfe_pkg::FX_ZERO) begin
              s_we    = 1'b1;
              s_wdata = a_q;
              count_d = count_q - 1'b1;
            end else begin
              div_start = 1'b1;
              div_dvd   = {a_mag, 16'd0};
              div_dsr   = b_mag;
              state_d   = S_DIVW;
            end
          end
          pfe_pkg::OP_MOD: begin
            if (b_mag[31:16] == 16'd0) begin
              s_we    = 1'b1;
              s_wdata = pfe_pkg::FX_ZERO;
              count_d = count_q - 1'b1;
            end else begin
              div_start = 1'b1;
              div_dvd   = {32'd0, a_mag[31:16]};
              div_dsr   = {16'd0, b_mag[31:16]};
              state_d   = S_DIVW;
            end
          end
          default: begin
            s_we    = 1'b1;
            count_d = count_q - 1'b1;
            case (cur_q.item.opcode)
              pfe_pkg::OP_AND: s_wdata = (a_q != 0 && b_q != 0) ? pfe_pkg::FX_ONE : 0;
              pfe_pkg::OP_OR:  s_wdata = (a_q != 0 || b_q != 0) ? pfe_pkg::FX_ONE : 0;
              pfe_pkg::OP_GE:  s_wdata = (a_q >= b_q) ? pfe_pkg::FX_ONE : 0;
              pfe_pkg::OP_LE:  s_wdata = (a_q <= b_q) ? pfe_pkg::FX_ONE : 0;
              pfe_pkg::OP_EQ:  s_wdata = (a_q == b_q) ? pfe_pkg::FX_ONE : 0;
              pfe_pkg::OP_NE:  s_wdata = (a_q != b_q) ? pfe_pkg::FX_ONE : 0;
              pfe_pkg::OP_ADD: s_wdata = pfe_pkg::sat32(64'(sum33));
              pfe_pkg::OP_SUB: s_wdata = pfe_pkg::sat32(64'(dif33));
              pfe_pkg::OP_LT:  s_wdata = (a_q < b_q) ? pfe_pkg::FX_ONE : 0;
              default:         s_wdata = (a_q > b_q) ? pfe_pkg::FX_ONE : 0;
            endcase
          end
        endcase
      end
      S_MUL: begin
        rnd     = (prod_q + 64'sd32768) >>> 16;
        s_we    = 1'b1;
        s_waddr = sec_a;
        s_wdata = pfe_pkg::sat32(rnd);
        count_d = count_q - 1'b1;
        state_d = S_FIN;
      end
      S_DIVW: begin
        if (div_done) begin
          s_we    = 1'b1;
          s_waddr = sec_a;
          s_wdata = (cur_q.item.opcode == pfe_pkg::OP_MOD) ? mod_val :
                    pfe_pkg::sat32(64'(q_signed));
          count_d = count_q - 1'b1;
          state_d = S_FIN;
        end
      end
      S_LK1: begin
        frac_d  = prod_q[15:0];
        ipneg_d = ip[25];
        if (clamp_q[cur_q.item.table_number]) begin
          lo_d = ip[25] ? '0 :
                 (ip > $signed({17'd0, len_m1})) ? len_m1[pfe_pkg::ENT_AW-1:0] :
                 ip[pfe_pkg::ENT_AW-1:0];
          hi_d = ip1[26] ? '0 :
                 (ip1 > $signed({18'd0, len_m1})) ? len_m1[pfe_pkg::ENT_AW-1:0] :
                 ip1[pfe_pkg::ENT_AW-1:0];
          state_d = S_LK2;
        end else begin
          div_start = 1'b1;
          div_dvd   = {22'd0, ip_mag};
          div_dsr   = {23'd0, len};
          state_d   = S_LKDIV;
        end
      end
      S_LKDIV: begin
        if (div_done) begin
          lo_d    = wrap_lo[pfe_pkg::ENT_AW-1:0];
          hi_d    = (wrap_lo + 9'd1 == len) ? '0 : 8'(wrap_lo + 9'd1);
          state_d = S_LK2;
        end
      end
      S_LK2: begin
        t_re    = 1'b1;
        state_d = S_LK3;
      end
      S_LK3: begin
        a_d = t_rdata;
        if (snap_q[cur_q.item.table_number]) begin
          s_we    = 1'b1;
          s_wdata = t_rdata;
          state_d = S_FIN;
        end else begin
          t_re    = 1'b1;
          t_raddr = {cur_q.item.table_number, hi_q};
          state_d = S_LK4;
        end
      end
      S_LK4: begin
        prod_d  = 64'(($signed({t_rdata[31], t_rdata}) - $signed({a_q[31], a_q})) *
                      $signed({1'b0, frac_q}));
        state_d = S_LK5;
      end
      S_LK5: begin
        rnd     = ((prod_q + 64'sd32768) >>> 16) + 64'(a_q);
        s_we    = 1'b1;
        s_wdata = pfe_pkg::sat32(rnd);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!cur_q.item.last_token) begin
          state_d = S_IDLE;
        end else begin
          if (err_q == pfe_pkg::ST_OK && count_q == '0) begin
            err_d = pfe_pkg::ST_UNDER;
          end
          s_re    = 1'b1;
          s_raddr = '0;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.result_value = (err_q != pfe_pkg::ST_OK) ? cur_q.item.default_value :
                               $signed(s_rdata);
          out_d.status = err_q;
          count_d = '0;
          err_d   = pfe_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= pfe_pkg::ST_OK;
      out_valid_q <= 1'b0;
      for (int i = 0; i < pfe_pkg::TABLE_COUNT; i++) begin
        len_q[i]   <= '0;
        clamp_q[i] <= 1'b0;
        snap_q[i]  <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (desc_we) begin
        len_q[tok_i.item.table_number]   <= in_len;
        clamp_q[tok_i.item.table_number] <= tok_i.item.table_clamp;
        snap_q[tok_i.item.table_number]  <= tok_i.item.table_snap;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    a_q     <= a_d;
    b_q     <= b_d;
    prod_q  <= prod_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    ipneg_q <= ipneg_d;
    frac_q  <= frac_d;
    out_q   <= out_d;
  end

  pfe_ram #(
    .WIDTH(32),
    .DEPTH(pfe_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .re_i   (s_re),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  pfe_ram #(
    .WIDTH(32),
    .DEPTH(pfe_pkg::TABLE_COUNT * pfe_pkg::TABLE_ENTRIES)
  ) u_tables (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(tok_i.item.operand),
    .re_i   (t_re),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  pfe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST && out_valid_q && out_stall_i) |=> (state_q == S_LAST))
    else $error("result would overwrite a waiting beat");

  a_err_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != pfe_pkg::ST_OK && state_q != S_LAST) |=> (err_q == $past(err_q)))
    else $error("first error code lost before the result");

endmodule

FILE: rtl/postfix_expression_evaluator_core.sv
// Postfix evaluator for Q16.16 expressions, one token per input beat. A token
// beat (command 0) pushes an operand, or pops and combines stack values; the
// beat flagged last_token yields one result beat holding the bottom stack value
// and status, or default_value with the first error code. Table entry and
// descriptor beats load the lookup tables and yield nothing. Beats enter a
// two-deep queue, so the source is held off only when two beats are waiting.
// Processing is one token at a time, taken by the back end only when idle:
// a push writes the stack, a simple operator reads both operands and writes
// the result, multiply adds a rounding step, an empty-table lookup writes
// zero, and a clamp-mode lookup reads one entry with snapping or two with
// interpolation. Divide, modulo and wrap-mode lookups wait on the 48-step
// bit-serial divider; the last token adds a read of the stack bottom, then
// the result beat is presented. Configuration registers sit on the APB port
// at byte addresses 0x00 to 0x18 and must only be written while idle.
module postfix_expression_evaluator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pfe_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfe_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  pfe_pkg::cfg_t cfg_q;
  pfe_pkg::tok_t tok;
  logic          tok_valid;
  logic          tok_pop;
  logic          cfg_we;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  // Register file; parameter values are resolved from it when a token is run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_time   <= pfe_pkg::FX_ZERO;
      cfg_q.param_source <= 2'd0;
      cfg_q.light_red    <= pfe_pkg::FX_ONE;
      cfg_q.light_green  <= pfe_pkg::FX_ONE;
      cfg_q.light_blue   <= pfe_pkg::FX_ONE;
      cfg_q.entity_rgba  <= 32'hffff_ffff;
      cfg_q.shader_time  <= pfe_pkg::FX_ZERO;
    end else if (cfg_we) begin
      case (reg_idx)
        pfe_pkg::REG_FRAME_TIME:   cfg_q.frame_time   <= pwdata;
        pfe_pkg::REG_PARAM_SOURCE: cfg_q.param_source <= pwdata[1:0];
        pfe_pkg::REG_LIGHT_RED:    cfg_q.light_red    <= pwdata;
        pfe_pkg::REG_LIGHT_GREEN:  cfg_q.light_green  <= pwdata;
        pfe_pkg::REG_LIGHT_BLUE:   cfg_q.light_blue   <= pwdata;
        pfe_pkg::REG_ENTITY_RGBA:  cfg_q.entity_rgba  <= pwdata;
        pfe_pkg::REG_SHADER_TIME:  cfg_q.shader_time  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfe_pkg::REG_FRAME_TIME:   prdata = cfg_q.frame_time;
      pfe_pkg::REG_PARAM_SOURCE: prdata = {30'd0, cfg_q.param_source};
      pfe_pkg::REG_LIGHT_RED:    prdata = cfg_q.light_red;
      pfe_pkg::REG_LIGHT_GREEN:  prdata = cfg_q.light_green;
      pfe_pkg::REG_LIGHT_BLUE:   prdata = cfg_q.light_blue;
      pfe_pkg::REG_ENTITY_RGBA:  prdata = cfg_q.entity_rgba;
      pfe_pkg::REG_SHADER_TIME:  prdata = cfg_q.shader_time;
      default:                   prdata = 32'd0;
    endcase
  end

  // Front end: takes beats, classifies them and queues them.
  pfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .tok_valid_o(tok_valid),
    .tok_pop_i  (tok_pop),
    .tok_o      (tok)
  );

  // Back end: stack, tables, arithmetic and the result register.
  pfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .tok_valid_i(tok_valid),
    .tok_pop_o  (tok_pop),
    .tok_i      (tok),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pfe_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pfe_pkg::out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk_i = ~clk_i;

  postfix_expression_evaluator_core dut (.*);

  // Behavioural model of the stack machine, its tables and its registers.
  // Every beat is applied to it as it is accepted; a beat that ends an
  // expression queues the predicted result for the checker.
  logic signed [31:0] m_frame, m_lred, m_lgreen, m_lblue, m_shtime;
  logic [1:0] m_src;
  logic [31:0] m_rgba;
  logic signed [31:0] m_stack [pfe_pkg::STACK_DEPTH];
  int unsigned m_depth;
  logic [1:0] m_err;
  logic signed [31:0] m_tab [pfe_pkg::TABLE_COUNT][pfe_pkg::TABLE_ENTRIES];
  int unsigned m_len [pfe_pkg::TABLE_COUNT];
  bit m_clamp [pfe_pkg::TABLE_COUNT], m_snap [pfe_pkg::TABLE_COUNT];

  pfe_pkg::out_t expected_results [$];
  int errors = 0, results_seen = 0, tokens_sent = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;

  function automatic logic signed [31:0] clip(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic longint fl16(input longint x);
    return x >>> 16;
  endfunction

  function automatic logic signed [31:0] param_val(input int k);
    if (k == 4) return (m_src != 0) ? clip(-longint'(m_shtime)) : 0;
    if (m_src[1]) begin
      case (k)
        0: return m_lred;
        1: return m_lgreen;
        2: return m_lblue;
        default: return pfe_pkg::FX_ONE;
      endcase
    end
    if (m_src != 0)
      return 32'(((longint'(m_rgba >> (24 - 8 * k)) & 255) * 65536 + 127) / 255);
    return pfe_pkg::FX_ONE;
  endfunction

  function automatic logic signed [31:0] table_lookup(input int t,
                                                      input logic signed [31:0] v);
    longint len, idx, ip, fr, lo, hi, a, d;
    len = m_len[t];
    if (len == 0) return 0;
    idx = longint'(v) * len;
    ip = fl16(idx);
    fr = idx - ip * 65536;
    lo = ip;
    hi = ip + 1;
    if (m_clamp[t]) begin
      if (lo < 0) lo = 0;
      if (lo > len - 1) lo = len - 1;
      if (hi < 0) hi = 0;
      if (hi > len - 1) hi = len - 1;
    end else begin
      lo = lo % len;
      if (lo < 0) lo += len;
      hi = hi % len;
      if (hi < 0) hi += len;
    end
    a = m_tab[t][lo];
    if (m_snap[t]) return 32'(a);
    d = longint'(m_tab[t][hi]) - a;
    return clip(a + fl16(d * fr + 32768));
  endfunction

  function automatic logic signed [31:0] combine(input logic [4:0] op,
                                                 input logic signed [31:0] a, b);
    longint ia, ib;
    case (op)
      pfe_pkg::OP_AND: return (a != 0 && b != 0) ? pfe_pkg::FX_ONE : 0;
      pfe_pkg::OP_OR:  return (a != 0 || b != 0) ? pfe_pkg::FX_ONE : 0;
      pfe_pkg::OP_GE:  return a >= b ? pfe_pkg::FX_ONE : 0;
      pfe_pkg::OP_LE:  return a <= b ? pfe_pkg::FX_ONE : 0;
      pfe_pkg::OP_EQ:  return a == b ? pfe_pkg::FX_ONE : 0;
      pfe_pkg::OP_NE:  return a != b ? pfe_pkg::FX_ONE : 0;
      pfe_pkg::OP_ADD: return clip(longint'(a) + b);
      pfe_pkg::OP_SUB: return clip(longint'(a) - b);
      pfe_pkg::OP_DIV: return (b == 0) ? a : clip((longint'(a) * 65536) / b);
      pfe_pkg::OP_MOD: begin
        ia = longint'(a) / 65536;
        ib = longint'(b) / 65536;
        if (ib == 0) return 0;
        return clip((ia % ib) * 65536);
      end
      pfe_pkg::OP_MUL: return clip(fl16(longint'(a) * b + 32768));
      pfe_pkg::OP_LT:  return a < b ? pfe_pkg::FX_ONE : 0;
      default: return a > b ? pfe_pkg::FX_ONE : 0;
    endcase
  endfunction

  function automatic void flag(input logic [1:0] code);
    if (m_err == pfe_pkg::ST_OK) m_err = code;
  endfunction

  function automatic void stack_push(input logic signed [31:0] v);
    if (m_depth >= pfe_pkg::STACK_DEPTH) flag(pfe_pkg::ST_OVER);
    else m_stack[m_depth++] = v;
  endfunction

  function automatic void evaluate_token(input pfe_pkg::in_t it);
    logic signed [31:0] a;
    case (it.opcode) inside
      pfe_pkg::OP_NUM: stack_push(it.operand);
      pfe_pkg::OP_TIME: stack_push(m_frame);
      [pfe_pkg::OP_PAR0:pfe_pkg::OP_PAR4]:
        stack_push(param_val(int'(it.opcode - pfe_pkg::OP_PAR0)));
      pfe_pkg::OP_ONE: stack_push(pfe_pkg::FX_ONE);
      pfe_pkg::OP_HALF: stack_push(pfe_pkg::FX_HALF);
      pfe_pkg::OP_ZERO: stack_push(pfe_pkg::FX_ZERO);
      pfe_pkg::OP_NEG, pfe_pkg::OP_TBL: begin
        if (m_depth < 1) flag(pfe_pkg::ST_UNDER);
        else begin
          a = m_stack[m_depth - 1];
          m_stack[m_depth - 1] = (it.opcode == pfe_pkg::OP_NEG) ? clip(-longint'(a))
                                 : table_lookup(int'(it.table_number), a);
        end
      end
      [pfe_pkg::OP_AND:pfe_pkg::OP_GT]: begin
        if (m_depth < 2) flag(pfe_pkg::ST_UNDER);
        else begin
          m_depth--;
          m_stack[m_depth - 1] = combine(it.opcode, m_stack[m_depth - 1], m_stack[m_depth]);
        end
      end
      default: flag(pfe_pkg::ST_BAD);
    endcase
  endfunction

  // Applies one accepted beat to the model and queues any result it yields.
  function automatic void model_beat(input pfe_pkg::in_t it);
    pfe_pkg::out_t r;
    case (it.command)
      pfe_pkg::CMD_ENTRY: begin
        m_tab[it.table_number][it.entry_index] = it.operand;
      end
      pfe_pkg::CMD_DESC: begin
        m_len[it.table_number] = (it.table_length > pfe_pkg::TABLE_ENTRIES) ?
                                 pfe_pkg::TABLE_ENTRIES : it.table_length;
        m_clamp[it.table_number] = it.table_clamp;
        m_snap[it.table_number] = it.table_snap;
      end
      pfe_pkg::CMD_TOKEN: begin
        if (m_err == pfe_pkg::ST_OK) evaluate_token(it);
        if (it.last_token) begin
          if (m_err == pfe_pkg::ST_OK && m_depth == 0) m_err = pfe_pkg::ST_UNDER;
          r.result_value = (m_err != pfe_pkg::ST_OK) ? it.default_value : m_stack[0];
          r.status = m_err;
          expected_results.push_back(r);
          m_depth = 0;
          m_err = pfe_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  endfunction

  // Result checker, sampling at the rising edge.
  always @(posedge clk_i) begin
    pfe_pkg::out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: value %0d status %0d",
               out_data_o.result_value, out_data_o.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.result_value !== e.result_value) begin
          $error("result_value: expected %0d, got %0d", e.result_value,
                 out_data_o.result_value);
          errors++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // Sends one beat: optional idle gap, then hold valid until accepted. Valid
  // is left high on return; the next beat's idle gap or drain() takes it down.
  task automatic send_beat(input pfe_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_beat(it);
    if (it.command == pfe_pkg::CMD_TOKEN) tokens_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_token(input logic [4:0] op, input logic signed [31:0] val = 0,
                            input bit last = 0, input logic [2:0] tn = 0);
    pfe_pkg::in_t it;
    it = '0;
    it.command = pfe_pkg::CMD_TOKEN;
    it.opcode = op;
    it.operand = val;
    it.table_number = tn;
    it.last_token = last;
    it.default_value = $urandom;
    send_beat(it);
  endtask

  task automatic write_entry(input int t, input int e, input logic signed [31:0] v);
    pfe_pkg::in_t it;
    it = '0;
    it.command = pfe_pkg::CMD_ENTRY;
    it.table_number = 3'(t);
    it.entry_index = 8'(e);
    it.operand = v;
    it.opcode = 5'($urandom);
    it.last_token = 1'($urandom);
    send_beat(it);
  endtask

  task automatic write_desc(input int t, input int len, input bit clamp, input bit snap);
    pfe_pkg::in_t it;
    it = '0;
    it.command = pfe_pkg::CMD_DESC;
    it.table_number = 3'(t);
    it.table_length = 9'(len);
    it.table_clamp = clamp;
    it.table_snap = snap;
    it.last_token = 1'($urandom);
    send_beat(it);
  endtask

  // Waits until all results have arrived and the tokens still queued have run,
  // which covers the two queued beats and the one being run.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  // Setup and access phases; psel stays high between back-to-back writes.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    case (idx)
      pfe_pkg::REG_FRAME_TIME: m_frame = v;
      pfe_pkg::REG_PARAM_SOURCE: m_src = v[1:0];
      pfe_pkg::REG_LIGHT_RED: m_lred = v;
      pfe_pkg::REG_LIGHT_GREEN: m_lgreen = v;
      pfe_pkg::REG_LIGHT_BLUE: m_lblue = v;
      pfe_pkg::REG_ENTITY_RGBA: m_rgba = v;
      default: m_shtime = v;
    endcase
  endtask

  task automatic set_registers(input logic [31:0] ft, input logic [1:0] src,
                               input logic [31:0] r, g, b, rgba, st);
    drain();
    reg_write(pfe_pkg::REG_FRAME_TIME, ft);
    reg_write(pfe_pkg::REG_PARAM_SOURCE, {30'd0, src});
    reg_write(pfe_pkg::REG_LIGHT_RED, r);
    reg_write(pfe_pkg::REG_LIGHT_GREEN, g);
    reg_write(pfe_pkg::REG_LIGHT_BLUE, b);
    reg_write(pfe_pkg::REG_ENTITY_RGBA, rgba);
    reg_write(pfe_pkg::REG_SHADER_TIME, st);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Each table gets its descriptor, then every entry below its length, so no
  // lookup can reach an unwritten entry. One length saturates to the maximum.
  task automatic test_table_load();
    int len [pfe_pkg::TABLE_COUNT];
    int fill;
    for (int t = 0; t < pfe_pkg::TABLE_COUNT; t++) begin
      len[t] = (t == 0) ? 0 : (t == 1) ? 511 : int'($urandom_range(1, 32));
      write_desc(t, len[t], t[0], t[1]);
    end
    for (int t = 0; t < pfe_pkg::TABLE_COUNT; t++) begin
      fill = (len[t] > pfe_pkg::TABLE_ENTRIES) ? pfe_pkg::TABLE_ENTRIES : len[t];
      for (int e = 0; e < fill; e++)
        write_entry(t, e, (e % 17 == 0) ? ((e & 1) ? 32'sh7fffffff : 32'sh80000000)
                                        : $signed($urandom) >>> $urandom_range(16));
    end
  endtask

  // Directed extremes: add, negate, divide and modulo on boundary values, and each error case.
  task automatic test_directed();
    send_token(pfe_pkg::OP_NUM, 32'sh7fffffff);
    send_token(pfe_pkg::OP_NUM, 32'sh7fffffff);
    send_token(pfe_pkg::OP_ADD, 0, 1);
    send_token(pfe_pkg::OP_NUM, 32'sh80000000);
    send_token(pfe_pkg::OP_NEG, 0, 1);
    send_token(pfe_pkg::OP_NUM, 32'sh00050000);
    send_token(pfe_pkg::OP_ZERO);
    send_token(pfe_pkg::OP_DIV, 0, 1);
    send_token(pfe_pkg::OP_NUM, 32'sh00050000);
    send_token(pfe_pkg::OP_HALF);
    send_token(pfe_pkg::OP_MOD, 0, 1);
    send_token(pfe_pkg::OP_NUM, -32'sh00070000);
    send_token(pfe_pkg::OP_NUM, 32'sh00020000);
    send_token(pfe_pkg::OP_MOD, 0, 1);
    send_token(pfe_pkg::OP_BAD, 0, 1);
    send_token(5'd31, 0, 1);
    send_token(pfe_pkg::OP_ADD, 0, 1);
    send_token(pfe_pkg::OP_ONE, 0, 1);
    for (int i = 0; i <= pfe_pkg::STACK_DEPTH; i++)
      send_token(pfe_pkg::OP_ONE, 0, i == pfe_pkg::STACK_DEPTH);
    send_token(pfe_pkg::OP_TIME);
    send_token(pfe_pkg::OP_PAR4, 0, 1);
    send_token(pfe_pkg::OP_ZERO, 0, 1);
  endtask

  // A well-formed expression of random shape, or occasionally a broken one.
  task automatic random_expression();
    int need, n;
    logic [4:0] op;
    n = $urandom_range(1, 12);
    need = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) op = 5'($urandom);
      else if (need < 2 || $urandom_range(2) == 0)
        op = (need >= 1 && $urandom_range(3) == 0) ?
             ($urandom_range(1) ? pfe_pkg::OP_NEG : pfe_pkg::OP_TBL) :
             5'($urandom_range(pfe_pkg::OP_NUM, pfe_pkg::OP_ZERO));
      else op = 5'($urandom_range(pfe_pkg::OP_AND, pfe_pkg::OP_GT));
      if (op >= pfe_pkg::OP_NUM && op <= pfe_pkg::OP_ZERO) need++;
      else if (op >= pfe_pkg::OP_AND && op <= pfe_pkg::OP_GT) need--;
      send_token(op, $urandom_range(3) ? $signed($urandom) >>> $urandom_range(20) : $urandom,
                 (i == n - 1) ? !($urandom_range(30) == 0) : ($urandom_range(40) == 0),
                 3'($urandom));
    end
  endtask

  task automatic test_random(input int beats, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (beats > 0) begin
      random_expression();
      beats -= 6;
    end
  endtask

  initial begin
    for (int t = 0; t < pfe_pkg::TABLE_COUNT; t++) begin
      m_len[t] = 0;
      m_clamp[t] = 0;
      m_snap[t] = 0;
    end
    m_depth = 0;
    m_err = pfe_pkg::ST_OK;
    m_frame = 0;
    m_src = 0;
    m_lred = pfe_pkg::FX_ONE;
    m_lgreen = pfe_pkg::FX_ONE;
    m_lblue = pfe_pkg::FX_ONE;
    m_rgba = 32'hffffffff;
    m_shtime = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_load();
    set_registers(32'h80000000, 2'd1, 32'h7fffffff, 32'h80000000, 0, 32'h00ff80a5,
                  32'h80000000);
    test_directed();
    test_random(500, 36, 61);
    set_registers(32'h7fffffff, 2'd2, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(500, 61, 36);
    set_registers($urandom, 2'd3, $urandom, $urandom, $urandom, $urandom, 32'h7fffffff);
    test_random(250, 0, 0);
    set_registers(0, 2'd0, pfe_pkg::FX_ONE, pfe_pkg::FX_ONE, pfe_pkg::FX_ONE, $urandom,
                  $urandom);
    test_random(250, 0, 0);
    drain();

    $display("Ran %0d token beats giving %0d result beats, at reset values and under",
             tokens_sent, results_seen);
    $display("four register settings, with table loads, error cases and three stall mixes.");
    if (errors == 0) begin
      $display("PASS postfix_expression_evaluator_core");
    end else begin
      $display("FAIL postfix_expression_evaluator_core");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL postfix_expression_evaluator_core");
    $finish;
  end
endmodule
